>>> rtl/core/zoned_braking_distance_core_defines.svh
// assertion macros shared by the braking distance rtl
// depends on nothing; users supply clk and rst_n in scope
`ifndef ZONED_BRAKING_DISTANCE_CORE_DEFINES_SVH
`define ZONED_BRAKING_DISTANCE_CORE_DEFINES_SVH

// same-cycle implication
`define ZBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define ZBD_ASSERT_AFTER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> rtl/core/zbd_pkg.sv
// types and constants for the zoned braking distance core
// depends on nothing
`default_nettype none

package zbd_pkg;

    localparam int DIST_FRAC_BITS_DEF = 4;
    localparam int NUM_BASE_W = 81;
    localparam int DEN_W = 84;
    localparam int QUOT_W = 32;
    localparam int DIV_STEPS = 32;
    localparam int SHIFT_QUARTIC = 10;
    localparam int SHIFT_LOW = 11;
    localparam int FRONT_STAGES = 7;

    localparam logic [15:0] KMH_RESET = 16'd922;
    localparam logic [16:0] BP1_RESET = 17'd10240;
    localparam logic [16:0] BP2_RESET = 17'd17920;
    localparam logic [15:0] DECEL_RESET = 16'd4096;

    typedef struct packed {
        logic [16:0] train_speed;
        logic [31:0] last_odometer;
        logic        odometer_present;
        logic [31:0] last_travel;
        logic        travel_present;
    } cmd_t;

    typedef struct packed {
        logic [31:0] braking_distance;
        logic [31:0] odometer_estimate;
        logic        saturated;
    } result_t;

    typedef enum logic [1:0] {
        ZONE_CONST,
        ZONE_CUBIC,
        ZONE_QUARTIC
    } zone_t;

    typedef enum logic [1:0] {
        REG_KMH_PER_MPS = 2'd0,
        REG_FIRST_BP    = 2'd1,
        REG_SECOND_BP   = 2'd2,
        REG_BASE_DECEL  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [47:0] den_const;
        logic [66:0] den_cubic;
        logic [83:0] den_quartic;
        logic [50:0] bp1_cube;
        logic [69:0] quartic_term;
    } derived_t;

endpackage

`default_nettype wire

>>> rtl/core/zbd_const.sv
// settles the configuration-only products and denominators over five stages
// depends on zbd_pkg
`default_nettype none

module zbd_const (
    input  wire logic              clk,
    input  wire logic [15:0]       kmh,
    input  wire logic [16:0]       bp1,
    input  wire logic [16:0]       bp2,
    input  wire logic [15:0]       decel,
    output zbd_pkg::derived_t      derived
);
    import zbd_pkg::*;

    logic [31:0] cc1_reg;
    logic [33:0] b1sq1_reg, b2sq1_reg;
    logic [15:0] a1_reg;
    logic [16:0] b1_1_reg, b2_1_reg;
    logic [47:0] ac2_2_reg;
    logic [50:0] b1cube2_reg;
    logic [67:0] b2q2_reg;
    logic [16:0] b1_2_reg, b2_2_reg;
    logic [64:0] ac2b1_3_reg;
    logic [67:0] t3_3_reg;
    logic [47:0] ac2_3_reg;
    logic [50:0] b1cube3_reg;
    logic [67:0] b2q3_reg;
    logic [16:0] b2_3_reg;
    logic [81:0] ac2b1b2_4_reg;
    logic [66:0] den2_4_reg;
    logic [69:0] z3c4_reg;
    logic [47:0] ac2_4_reg;
    logic [50:0] b1cube4_reg;
    derived_t    derived_reg;
    derived_t    derived_next;

    always_comb
    begin
        derived_next.den_const    = ac2_4_reg;
        derived_next.den_cubic    = den2_4_reg;
        derived_next.den_quartic  = 84'(ac2b1b2_4_reg) + (84'(ac2b1b2_4_reg) << 1);
        derived_next.bp1_cube     = b1cube4_reg;
        derived_next.quartic_term = z3c4_reg;
    end

    always_ff @(posedge clk)
    begin
        cc1_reg       <= 32'(kmh) * 32'(kmh);
        b1sq1_reg     <= 34'(bp1) * 34'(bp1);
        b2sq1_reg     <= 34'(bp2) * 34'(bp2);
        a1_reg        <= decel;
        b1_1_reg      <= bp1;
        b2_1_reg      <= bp2;

        ac2_2_reg     <= 48'(a1_reg) * 48'(cc1_reg);
        b1cube2_reg   <= 51'(b1sq1_reg) * 51'(b1_1_reg);
        b2q2_reg      <= 68'(b2sq1_reg) * 68'(b2sq1_reg);
        b1_2_reg      <= b1_1_reg;
        b2_2_reg      <= b2_1_reg;

        ac2b1_3_reg   <= 65'(ac2_2_reg) * 65'(b1_2_reg);
        t3_3_reg      <= 68'(b1cube2_reg) * 68'(b2_2_reg);
        ac2_3_reg     <= ac2_2_reg;
        b1cube3_reg   <= b1cube2_reg;
        b2q3_reg      <= b2q2_reg;
        b2_3_reg      <= b2_2_reg;

        ac2b1b2_4_reg <= 82'(ac2b1_3_reg) * 82'(b2_3_reg);
        den2_4_reg    <= 67'(ac2b1_3_reg) + (67'(ac2b1_3_reg) << 1);
        z3c4_reg      <= 70'(b2q3_reg) + (70'(t3_3_reg) << 1);
        ac2_4_reg     <= ac2_3_reg;
        b1cube4_reg   <= b1cube3_reg;

        derived_reg   <= derived_next;
    end

    assign derived = derived_reg;

endmodule

`default_nettype wire

>>> rtl/core/zbd_front.sv
// speed powers, zone select and numerator/denominator build, seven stages
// depends on zbd_pkg
`default_nettype none

module zbd_front #(
    parameter int DIST_FRAC_BITS = zbd_pkg::DIST_FRAC_BITS_DEF,
    localparam int NUM_W = zbd_pkg::NUM_BASE_W + DIST_FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire zbd_pkg::cmd_t          cmd,
    input  wire logic [16:0]            bp1,
    input  wire logic [16:0]            bp2,
    input  wire zbd_pkg::derived_t      derived,
    output logic                        out_valid,
    output logic [NUM_W-1:0]            num,
    output logic [zbd_pkg::DEN_W-1:0]   den,
    output logic                        sat,
    output logic [31:0]                 odo,
    output logic [31:0]                 trav
);
    import zbd_pkg::*;

    localparam int SH_LOW = SHIFT_LOW + DIST_FRAC_BITS;
    localparam int SH_Q = SHIFT_QUARTIC + DIST_FRAC_BITS;
    localparam int CMP_W = DEN_W + QUOT_W;

    logic        valid_reg [0:FRONT_STAGES-1];
    zone_t       zone_reg  [0:FRONT_STAGES-1];
    logic [31:0] odo_reg   [0:FRONT_STAGES-1];
    logic [31:0] trav_reg  [0:FRONT_STAGES-1];

    zone_t       zone_next;
    logic [16:0] s1_reg, s2_reg;
    logic [33:0] sq2_reg, sq3_reg, sq4_reg;
    logic [50:0] cube3_reg;
    logic [67:0] quart3_reg;
    logic [51:0] m2_4_reg;
    logic [69:0] m3_4_reg;
    logic [NUM_W-1:0] var5_reg, var_next;
    logic [NUM_W-1:0] num6_reg, num_next;
    logic [NUM_W-1:0] num7_reg;
    logic [DEN_W-1:0] den7_reg, den_next;
    logic             sat7_reg, sat_next;

    always_comb
    begin
        if (cmd.train_speed <= bp1)
            zone_next = ZONE_CONST;
        else if (cmd.train_speed < bp2)
            zone_next = ZONE_CUBIC;
        else
            zone_next = ZONE_QUARTIC;
    end

    always_comb
    begin
        case (zone_reg[3])
            ZONE_CONST:   var_next = NUM_W'(sq4_reg) << SH_LOW;
            ZONE_CUBIC:   var_next = NUM_W'(m2_4_reg) << SH_LOW;
            default:      var_next = NUM_W'(m3_4_reg) << SH_Q;
        endcase
    end

    always_comb
    begin
        case (zone_reg[4])
            ZONE_CONST:   num_next = var5_reg;
            ZONE_CUBIC:   num_next = var5_reg + (NUM_W'(derived.bp1_cube) << SH_LOW);
            default:      num_next = var5_reg + (NUM_W'(derived.quartic_term) << SH_Q);
        endcase
    end

    always_comb
    begin
        case (zone_reg[5])
            ZONE_CONST:   den_next = DEN_W'(derived.den_const);
            ZONE_CUBIC:   den_next = DEN_W'(derived.den_cubic);
            default:      den_next = derived.den_quartic;
        endcase
        sat_next = CMP_W'(num6_reg) >= (CMP_W'(den_next) << QUOT_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < FRONT_STAGES; j++)
                valid_reg[j] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int j = 1; j < FRONT_STAGES; j++)
                valid_reg[j] <= valid_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        zone_reg[0] <= zone_next;
        odo_reg[0]  <= cmd.odometer_present ? cmd.last_odometer : 32'd0;
        trav_reg[0] <= cmd.travel_present ? cmd.last_travel : 32'd0;
        for (int j = 1; j < FRONT_STAGES; j++)
        begin
            zone_reg[j] <= zone_reg[j-1];
            odo_reg[j]  <= odo_reg[j-1];
            trav_reg[j] <= trav_reg[j-1];
        end
        s1_reg     <= cmd.train_speed;
        sq2_reg    <= 34'(s1_reg) * 34'(s1_reg);
        s2_reg     <= s1_reg;
        sq3_reg    <= sq2_reg;
        cube3_reg  <= 51'(sq2_reg) * 51'(s2_reg);
        quart3_reg <= 68'(sq2_reg) * 68'(sq2_reg);
        sq4_reg    <= sq3_reg;
        m2_4_reg   <= {cube3_reg, 1'b0};
        m3_4_reg   <= 70'(quart3_reg) + (70'(quart3_reg) << 1);
        var5_reg   <= var_next;
        num6_reg   <= num_next;
        num7_reg   <= num6_reg;
        den7_reg   <= den_next;
        sat7_reg   <= sat_next;
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign num       = num7_reg;
    assign den       = den7_reg;
    assign sat       = sat7_reg;
    assign odo       = odo_reg[FRONT_STAGES-1];
    assign trav      = trav_reg[FRONT_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/zbd_div.sv
// restoring divider, one quotient bit per pipeline stage
// depends on zbd_pkg
`default_nettype none

module zbd_div #(
    parameter int DIST_FRAC_BITS = zbd_pkg::DIST_FRAC_BITS_DEF,
    localparam int NUM_W = zbd_pkg::NUM_BASE_W + DIST_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [NUM_W-1:0]             num,
    input  wire logic [zbd_pkg::DEN_W-1:0]    den,
    input  wire logic                         in_sat,
    input  wire logic [31:0]                  in_odo,
    input  wire logic [31:0]                  in_trav,
    output logic                              out_valid,
    output logic [zbd_pkg::QUOT_W-1:0]        quot,
    output logic                              out_sat,
    output logic [31:0]                       out_odo,
    output logic [31:0]                       out_trav
);
    import zbd_pkg::*;

    localparam int CMP_W = DEN_W + QUOT_W;

    logic              valid_reg [0:DIV_STEPS-1];
    logic [NUM_W-1:0]  rem_reg   [0:DIV_STEPS-1];
    logic [DEN_W-1:0]  den_reg   [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] q_reg     [0:DIV_STEPS-1];
    logic              sat_reg   [0:DIV_STEPS-1];
    logic [31:0]       odo_reg   [0:DIV_STEPS-1];
    logic [31:0]       trav_reg  [0:DIV_STEPS-1];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        localparam int K = QUOT_W - 1 - i;
        logic              v_prev;
        logic [NUM_W-1:0]  r_prev;
        logic [DEN_W-1:0]  d_prev;
        logic [QUOT_W-1:0] q_prev;
        logic              s_prev;
        logic [31:0]       o_prev;
        logic [31:0]       t_prev;
        logic [CMP_W-1:0]  shifted;
        logic              ge;
        logic [NUM_W-1:0]  rem_next;

        if (i == 0)
        begin : g_first
            assign v_prev = in_valid;
            assign r_prev = num;
            assign d_prev = den;
            assign q_prev = '0;
            assign s_prev = in_sat;
            assign o_prev = in_odo;
            assign t_prev = in_trav;
        end
        else
        begin : g_rest
            assign v_prev = valid_reg[i-1];
            assign r_prev = rem_reg[i-1];
            assign d_prev = den_reg[i-1];
            assign q_prev = q_reg[i-1];
            assign s_prev = sat_reg[i-1];
            assign o_prev = odo_reg[i-1];
            assign t_prev = trav_reg[i-1];
        end

        always_comb
        begin
            shifted  = CMP_W'(d_prev) << K;
            ge       = CMP_W'(r_prev) >= shifted;
            rem_next = ge ? r_prev - shifted[NUM_W-1:0] : r_prev;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            den_reg[i]  <= d_prev;
            q_reg[i]    <= {q_prev[QUOT_W-2:0], ge};
            sat_reg[i]  <= s_prev;
            odo_reg[i]  <= o_prev;
            trav_reg[i] <= t_prev;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quot      = q_reg[DIV_STEPS-1];
    assign out_sat   = sat_reg[DIV_STEPS-1];
    assign out_odo   = odo_reg[DIV_STEPS-1];
    assign out_trav  = trav_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/zoned_braking_distance_core.sv
// top level: config registers, front stages, divider and result stage
// depends on zbd_pkg, zbd_const, zbd_front, zbd_div and the defines header
//
// channel   direction  handshake               payload
// command   in         start, busy             cmd (cmd_t)
// result    out        done                    result (result_t)
// config    in         psel/penable/pwrite     paddr, pwdata, prdata
//
// one transfer per cycle
// start to done passes 7 front stages, 32 divider stages (one quotient bit each), one result stage
// busy stays low; results show for one cycle and cannot be held off
// reset clears valid bits and restores register defaults
`default_nettype none
`include "zoned_braking_distance_core_defines.svh"

module zoned_braking_distance_core #(
    parameter int DIST_FRAC_BITS = zbd_pkg::DIST_FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire zbd_pkg::cmd_t   cmd,
    output logic                 done,
    output zbd_pkg::result_t     result,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import zbd_pkg::*;

    localparam int NUM_W = NUM_BASE_W + DIST_FRAC_BITS;
    localparam int LATENCY = FRONT_STAGES + DIV_STEPS + 1;

    logic [15:0] kmh_reg;
    logic [16:0] bp1_reg;
    logic [16:0] bp2_reg;
    logic [15:0] decel_reg;
    logic [15:0] kmh_fix, decel_fix;
    logic [16:0] bp1_fix, bp2_fix;
    logic        wr_en;
    reg_idx_t    wr_idx;

    derived_t          derived;
    logic              f_valid, f_sat;
    logic [NUM_W-1:0]  f_num;
    logic [DEN_W-1:0]  f_den;
    logic [31:0]       f_odo, f_trav;
    logic              d_valid, d_sat;
    logic [QUOT_W-1:0] d_quot;
    logic [31:0]       d_odo, d_trav;

    logic        done_reg;
    result_t     result_reg, result_next;
    logic [31:0] brake_dist;
    logic [33:0] sum;

    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmh_reg   <= KMH_RESET;
            bp1_reg   <= BP1_RESET;
            bp2_reg   <= BP2_RESET;
            decel_reg <= DECEL_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_KMH_PER_MPS: kmh_reg   <= pwdata[15:0];
                REG_FIRST_BP:    bp1_reg   <= pwdata[16:0];
                REG_SECOND_BP:   bp2_reg   <= pwdata[16:0];
                REG_BASE_DECEL:  decel_reg <= pwdata[15:0];
                default:         kmh_reg   <= kmh_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_KMH_PER_MPS: prdata = 32'(kmh_reg);
            REG_FIRST_BP:    prdata = 32'(bp1_reg);
            REG_SECOND_BP:   prdata = 32'(bp2_reg);
            REG_BASE_DECEL:  prdata = 32'(decel_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        kmh_fix   = (kmh_reg == '0) ? 16'd1 : kmh_reg;
        bp1_fix   = (bp1_reg == '0) ? 17'd1 : bp1_reg;
        decel_fix = (decel_reg == '0) ? 16'd1 : decel_reg;
        bp2_fix   = (bp2_reg < bp1_fix) ? bp1_fix : bp2_reg;
    end

    zbd_const u_const (
        .clk     (clk),
        .kmh     (kmh_fix),
        .bp1     (bp1_fix),
        .bp2     (bp2_fix),
        .decel   (decel_fix),
        .derived (derived)
    );

    zbd_front #(
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .cmd       (cmd),
        .bp1       (bp1_fix),
        .bp2       (bp2_fix),
        .derived   (derived),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .sat       (f_sat),
        .odo       (f_odo),
        .trav      (f_trav)
    );

    zbd_div #(
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .in_sat    (f_sat),
        .in_odo    (f_odo),
        .in_trav   (f_trav),
        .out_valid (d_valid),
        .quot      (d_quot),
        .out_sat   (d_sat),
        .out_odo   (d_odo),
        .out_trav  (d_trav)
    );

    always_comb
    begin
        brake_dist = d_sat ? 32'hFFFF_FFFF : d_quot;
        sum  = 34'(brake_dist) + 34'(d_odo) + 34'(d_trav);
        result_next.braking_distance  = brake_dist;
        result_next.odometer_estimate = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
        result_next.saturated         = d_sat || (sum[33:32] != 2'b00);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ZBD_ASSERT_AFTER(a_latency, start && !busy, LATENCY, done, "result transfer missing")
    `ZBD_ASSERT_NOW(a_sum_order, done && !result.saturated,
        result.odometer_estimate >= result.braking_distance, "estimate below distance")
    `ZBD_ASSERT_NOW(a_sat_clip, done && result.saturated,
        result.odometer_estimate == 32'hFFFF_FFFF, "saturated but not clipped")

endmodule

`default_nettype wire

>>> tb/zoned_braking_distance_core_checker.sv
// checker for the zoned braking distance core: predicts each result from the
// accepted command and the shadow registers; depends on zbd_pkg
`timescale 1ns / 1ps

module zoned_braking_distance_core_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           busy,
    input  zbd_pkg::cmd_t       cmd,
    input  wire logic           done,
    input  zbd_pkg::result_t    result,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic           pready,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output int                  fail_count,
    output int                  pending_count
);
    import zbd_pkg::*;

    logic [15:0] kmh_q;
    logic [16:0] bp1_q;
    logic [16:0] bp2_q;
    logic [15:0] decel_q;
    result_t     distance_q[$];

    function automatic result_t predict_distance(cmd_t c);
        logic [255:0] num;
        logic [255:0] den;
        logic [255:0] s;
        logic [255:0] b1;
        logic [255:0] b2;
        logic [255:0] dec;
        logic [255:0] k;
        logic [255:0] q;
        logic [33:0]  sum;
        result_t      r;
        s   = 256'(c.train_speed);
        b1  = (bp1_q == 17'd0) ? 256'd1 : 256'(bp1_q);
        b2  = (bp2_q < b1[16:0]) ? b1 : 256'(bp2_q);
        dec = (decel_q == 16'd0) ? 256'd1 : 256'(decel_q);
        k   = (kmh_q == 16'd0) ? 256'd1 : 256'(kmh_q);
        den = dec * k * k;
        r.saturated = 1'b0;
        if (s <= b1)
            num = (s * s) << (SHIFT_LOW + DIST_FRAC_BITS_DEF);
        else if (s < b2)
        begin
            num = (2 * s * s * s + b1 * b1 * b1) << (SHIFT_LOW + DIST_FRAC_BITS_DEF);
            den = den * 3 * b1;
        end
        else
        begin
            num = (3 * s * s * s * s + b2 * b2 * b2 * b2 + 2 * b1 * b1 * b1 * b2)
                << (SHIFT_QUARTIC + DIST_FRAC_BITS_DEF);
            den = den * 3 * b1 * b2;
        end
        q = num / den;
        if (q > 256'hFFFFFFFF)
        begin
            r.braking_distance = 32'hFFFFFFFF;
            r.saturated = 1'b1;
        end
        else
            r.braking_distance = q[31:0];
        sum = 34'(r.braking_distance);
        if (c.odometer_present)
            sum = sum + 34'(c.last_odometer);
        if (c.travel_present)
            sum = sum + 34'(c.last_travel);
        if (sum > 34'hFFFFFFFF)
        begin
            sum = 34'hFFFFFFFF;
            r.saturated = 1'b1;
        end
        r.odometer_estimate = sum[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmh_q   <= KMH_RESET;
            bp1_q   <= BP1_RESET;
            bp2_q   <= BP2_RESET;
            decel_q <= DECEL_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_KMH_PER_MPS: kmh_q   <= pwdata[15:0];
                REG_FIRST_BP:    bp1_q   <= pwdata[16:0];
                REG_SECOND_BP:   bp2_q   <= pwdata[16:0];
                REG_BASE_DECEL:  decel_q <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    initial fail_count = 0;
    initial pending_count = 0;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (distance_q.size() == 0)
                    report_mismatch("unexpected transfer", 32'd0, 32'd0);
                else
                begin
                    want = distance_q.pop_front();
                    if (result.braking_distance !== want.braking_distance)
                        report_mismatch("braking_distance", result.braking_distance,
                                        want.braking_distance);
                    if (result.odometer_estimate !== want.odometer_estimate)
                        report_mismatch("odometer_estimate", result.odometer_estimate,
                                        want.odometer_estimate);
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(result.saturated),
                                        32'(want.saturated));
                end
            end
            if (start && !busy)
                distance_q.push_back(predict_distance(cmd));
        end
        pending_count <= distance_q.size();
    end
endmodule

>>> tb/zoned_braking_distance_core_tb.sv
// top of the zoned braking distance testbench: clock, reset, register writes
// and command stimulus; depends on zbd_pkg, the core and the checker
`timescale 1ns / 1ps

module zoned_braking_distance_core_tb;
    import zbd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          cycle_count;

    zoned_braking_distance_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    zoned_braking_distance_core_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("[zoned_braking_distance_core] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_cmd(cmd_t c, bit gaps);
        while (gaps && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic cmd_t random_cmd(logic [16:0] bp1, logic [16:0] bp2);
        cmd_t c;
        c.last_odometer    = $urandom;
        c.last_travel      = $urandom;
        c.odometer_present = 1'($urandom_range(1));
        c.travel_present   = 1'($urandom_range(1));
        case ($urandom_range(5))
            0: c.train_speed = 17'($urandom_range(8));
            1: c.train_speed = 17'(bp1 + $urandom_range(2) - 1);
            2: c.train_speed = 17'(bp2 + $urandom_range(2) - 1);
            3: c.train_speed = 17'(17'h1FFFF - $urandom_range(3));
            default: c.train_speed = 17'($urandom);
        endcase
        if ($urandom_range(3) == 0)
        begin
            c.last_odometer = c.last_odometer >> $urandom_range(31);
            c.last_travel   = c.last_travel >> $urandom_range(31);
        end
        return c;
    endfunction

    task automatic set_config(logic [15:0] kmh, logic [16:0] bp1, logic [16:0] bp2,
                              logic [15:0] decel);
        write_reg(REG_KMH_PER_MPS, 32'(kmh));
        write_reg(REG_FIRST_BP, 32'(bp1));
        write_reg(REG_SECOND_BP, 32'(bp2));
        write_reg(REG_BASE_DECEL, 32'(decel));
    endtask

    initial
    begin
        cmd_t        c;
        logic [15:0] kmh;
        logic [16:0] bp1;
        logic [16:0] bp2;
        logic [15:0] decel;
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands at reset settings
        c = '0;
        send_cmd(c, 0);
        c = '{17'h1FFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1};
        send_cmd(c, 0);
        c = '{17'd10240, 32'd1000, 1'b0, 32'd5, 1'b1};
        send_cmd(c, 0);
        c = '{17'd10241, 32'd1000, 1'b1, 32'd5, 1'b0};
        send_cmd(c, 0);
        c = '{17'd17919, 32'h80000000, 1'b1, 32'h80000000, 1'b1};
        send_cmd(c, 0);
        c = '{17'd17920, 32'd0, 1'b0, 32'd0, 1'b0};
        send_cmd(c, 0);
        start <= 1'b0;
        wait_idle();

        // zero registers are taken as one, out of order breakpoints
        set_config(16'd0, 17'd0, 17'd0, 16'd0);
        c = '{17'd1, 32'd7, 1'b1, 32'd9, 1'b1};
        send_cmd(c, 0);
        c = '{17'd0, 32'd7, 1'b1, 32'd9, 1'b1};
        send_cmd(c, 0);
        start <= 1'b0;
        wait_idle();
        set_config(16'hFFFF, 17'd30000, 17'd20000, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_cmd(random_cmd(17'd30000, 17'd30000), 0);
        start <= 1'b0;
        wait_idle();
        set_config(16'd1, 17'h1FFFF, 17'h1FFFF, 16'd1);
        c = '{17'h1FFFF, 32'd0, 1'b0, 32'd0, 1'b0};
        send_cmd(c, 0);
        start <= 1'b0;
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            kmh   = (phase == 0) ? KMH_RESET : 16'($urandom_range(65535, 1));
            bp1   = 17'($urandom_range(131071, 1));
            bp2   = ($urandom_range(4) == 0) ? 17'($urandom_range(131071, 1))
                  : 17'(bp1 + $urandom_range(131071 - bp1));
            decel = 16'($urandom_range(65535, 1));
            if (phase == 1)
            begin
                kmh   = 16'hFFFF;
                decel = 16'hFFFF;
            end
            set_config(kmh, bp1, bp2, decel);
            for (int i = 0; i < 150; i++)
            begin
                send_cmd(random_cmd(bp1, bp2), phase != 2);
                if (i == 75 && phase == 3)
                begin
                    start <= 1'b0;
                    wait_idle();
                end
            end
            start <= 1'b0;
            wait_idle();
        end

        if (fail_count == 0)
            $display("[zoned_braking_distance_core] OK");
        else
            $display("[zoned_braking_distance_core] ERROR");
        $finish;
    end
endmodule
